>>> hdl/markup_tag_nesting_checker_core_macros.svh
// Assertion macros for the markup tag nesting checker core.
`ifndef MARKUP_TAG_NESTING_CHECKER_CORE_MACROS_SVH
`define MARKUP_TAG_NESTING_CHECKER_CORE_MACROS_SVH
`ifndef SYNTH
`define MTNC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define MTNC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define MTNC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MTNC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/mtnc_pkg.sv
// Types and constants shared by the markup tag nesting checker.
`timescale 1ns / 1ps
package mtnc_pkg;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [23:0] NAME_IMG = 24'h676D69;

   localparam logic [2:0] F_OK       = 3'd0;
   localparam logic [2:0] F_MISMATCH = 3'd1;
   localparam logic [2:0] F_EMPTY    = 3'd2;
   localparam logic [2:0] F_UNCLOSED = 3'd3;
   localparam logic [2:0] F_OVERFLOW = 3'd4;
   localparam logic [2:0] F_UNTERM   = 3'd5;

   typedef enum logic [5:0] {
      PH_OUTSIDE    = 6'b000001,
      PH_AFTER_LT   = 6'b000010,
      PH_OPEN_NAME  = 6'b000100,
      PH_CLOSE_NAME = 6'b001000,
      PH_OPEN_SKIP  = 6'b010000,
      PH_CLOSE_SKIP = 6'b100000
   } phase_type;

   typedef struct packed {
      logic push;
      logic pop;
   } shift_ctl_type;

   typedef struct packed {
      logic       valid_res;
      logic [2:0] fault;
   } result_type;

endpackage

>>> hdl/mtnc_ifc.sv
// Handshake interfaces for the character and verdict channels.
`timescale 1ns / 1ps
interface mtnc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;
   modport source (output valid, output ch, output last, input ready);
   modport sink (input valid, input ch, input last, output ready);
endinterface

interface mtnc_rsp_if;
   logic       valid;
   logic       ready;
   logic       valid_res;
   logic [2:0] fault;
   modport source (output valid, output valid_res, output fault, input ready);
   modport sink (input valid, input valid_res, input fault, output ready);
endinterface

>>> hdl/mtnc_cell.sv
// One stack cell: holds one tag name, shifts down on push and up on pop.
`timescale 1ns / 1ps
module mtnc_cell #(
   parameter int NAME_W = 64
) (
   input  logic                   clock,
   input  mtnc_pkg::shift_ctl_type ctl,
   input  logic [NAME_W-1:0]      above,
   input  logic [NAME_W-1:0]      below,
   output logic [NAME_W-1:0]      q
);

   logic [NAME_W-1:0] name_ff;
   logic [NAME_W-1:0] name_in;

   always_comb begin
      name_in = name_ff;
      if (ctl.push) begin
         name_in = above;
      end else if (ctl.pop) begin
         name_in = below;
      end
   end

   always_ff @(posedge clock) begin
      name_ff <= name_in;
   end

   assign q = name_ff;

endmodule

>>> hdl/mtnc_parser.sv
// Tag parser: phase, name buffer, stack depth, sticky fault and verdict.
`timescale 1ns / 1ps
module mtnc_parser #(
   parameter int STACK_DEPTH = 16,
   parameter int NAME_CHARS  = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [7:0]                 ch,
   input  logic                       last,
   input  logic [NAME_CHARS*8-1:0]    top_name,
   output logic [NAME_CHARS*8-1:0]    name_buf,
   output mtnc_pkg::shift_ctl_type    ctl,
   output mtnc_pkg::result_type       result
);

   localparam int NAME_W = NAME_CHARS * 8;
   localparam int LEN_W  = $clog2(NAME_CHARS + 1);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   mtnc_pkg::phase_type phase_ff, phase_in;
   logic [NAME_W-1:0]   buf_ff, buf_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [2:0]          fault_ff, fault_in;
   logic                do_name;
   logic                do_finish;
   logic                is_close;
   logic                push_c;
   logic                pop_c;
   logic                is_img;

   assign is_img = (len_ff >= LEN_W'(3)) && (buf_ff[23:0] == mtnc_pkg::NAME_IMG);

   always_comb begin
      phase_in  = phase_ff;
      buf_in    = buf_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      fault_in  = fault_ff;
      do_name   = 1'b0;
      do_finish = 1'b0;
      is_close  = 1'b0;
      push_c    = 1'b0;
      pop_c     = 1'b0;
      if (fault_ff == mtnc_pkg::F_OK) begin
         case (phase_ff)
            mtnc_pkg::PH_OUTSIDE: begin
               if (ch == mtnc_pkg::CH_LT) begin
                  buf_in   = '0;
                  len_in   = '0;
                  phase_in = mtnc_pkg::PH_AFTER_LT;
               end
            end
            mtnc_pkg::PH_AFTER_LT: begin
               if (ch == mtnc_pkg::CH_SLASH) begin
                  phase_in = mtnc_pkg::PH_CLOSE_NAME;
               end else begin
                  phase_in = mtnc_pkg::PH_OPEN_NAME;
                  do_name  = 1'b1;
               end
            end
            mtnc_pkg::PH_OPEN_NAME: begin
               do_name = 1'b1;
            end
            mtnc_pkg::PH_CLOSE_NAME: begin
               do_name  = 1'b1;
               is_close = 1'b1;
            end
            mtnc_pkg::PH_OPEN_SKIP: begin
               do_finish = (ch == mtnc_pkg::CH_GT);
            end
            mtnc_pkg::PH_CLOSE_SKIP: begin
               do_finish = (ch == mtnc_pkg::CH_GT);
               is_close  = 1'b1;
            end
            default: begin
               phase_in = mtnc_pkg::PH_OUTSIDE;
            end
         endcase
         if (do_name) begin
            if (ch == mtnc_pkg::CH_GT) begin
               do_finish = 1'b1;
            end else if (ch == mtnc_pkg::CH_SPACE || ch == mtnc_pkg::CH_SLASH ||
                         ch == mtnc_pkg::CH_NUL) begin
               phase_in = is_close ? mtnc_pkg::PH_CLOSE_SKIP : mtnc_pkg::PH_OPEN_SKIP;
            end else if (len_ff >= LEN_W'(NAME_CHARS)) begin
               fault_in = mtnc_pkg::F_OVERFLOW;
            end else begin
               for (int k = 0; k < NAME_CHARS; k++) begin
                  if (len_ff == LEN_W'(k)) begin
                     buf_in[8*k +: 8] = ch;
                  end
               end
               len_in = len_ff + LEN_W'(1);
            end
         end
         if (do_finish) begin
            phase_in = mtnc_pkg::PH_OUTSIDE;
            if (is_close) begin
               if (count_ff == '0) begin
                  fault_in = mtnc_pkg::F_EMPTY;
               end else if (top_name != buf_ff) begin
                  fault_in = mtnc_pkg::F_MISMATCH;
               end else begin
                  pop_c    = 1'b1;
                  count_in = count_ff - CNT_W'(1);
               end
            end else if (!is_img) begin
               if (count_ff == CNT_W'(STACK_DEPTH)) begin
                  fault_in = mtnc_pkg::F_OVERFLOW;
               end else begin
                  push_c   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
      end
   end

   always_comb begin
      if (fault_in != mtnc_pkg::F_OK) begin
         result.fault = fault_in;
      end else if (phase_in != mtnc_pkg::PH_OUTSIDE) begin
         result.fault = mtnc_pkg::F_UNTERM;
      end else if (count_in != '0) begin
         result.fault = mtnc_pkg::F_UNCLOSED;
      end else begin
         result.fault = mtnc_pkg::F_OK;
      end
      result.valid_res = (result.fault == mtnc_pkg::F_OK);
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && last)) begin
         phase_ff <= mtnc_pkg::PH_OUTSIDE;
         buf_ff   <= '0;
         len_ff   <= '0;
         count_ff <= '0;
         fault_ff <= mtnc_pkg::F_OK;
      end else if (accept) begin
         phase_ff <= phase_in;
         buf_ff   <= buf_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         fault_ff <= fault_in;
      end
   end

   assign name_buf = buf_ff;
   assign ctl.push = accept && push_c;
   assign ctl.pop  = accept && pop_c;

endmodule

>>> hdl/markup_tag_nesting_checker_core.sv
// A verdict appears on rsp the cycle after its last character is taken if the result buffer is empty or its
// entry is being taken; else it waits in the buffer. Throughput: one character per cycle while req is not stalled;
// the parser and the top-of-stack compare are combinational and the name stack shifts one cell per push or pop.
// A two-entry result buffer holds verdicts; req stalls only while both are full.
// Reset (synchronous, active high) empties the stack, parser and result buffer.
`timescale 1ns / 1ps
`include "markup_tag_nesting_checker_core_macros.svh"
module markup_tag_nesting_checker_core #(
   parameter int STACK_DEPTH = 16,
   parameter int NAME_CHARS  = 8
) (
   input logic              clock,
   input logic              reset,
   mtnc_req_if.sink         req_bus,
   mtnc_rsp_if.source       rsp_bus
);

   localparam int NAME_W = NAME_CHARS * 8;

   logic                     accept;
   logic                     push_res;
   logic                     pop_res;
   logic [NAME_W-1:0]        name_buf;
   logic [NAME_W-1:0]        cell_q [STACK_DEPTH];
   mtnc_pkg::shift_ctl_type  ctl;
   mtnc_pkg::result_type     result;
   mtnc_pkg::result_type     out_ff, out_in, skid_ff, skid_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     skid_valid_ff, skid_valid_in;

   assign req_bus.ready = !skid_valid_ff;
   assign accept        = req_bus.valid && req_bus.ready;

   mtnc_parser #(
      .STACK_DEPTH(STACK_DEPTH),
      .NAME_CHARS (NAME_CHARS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .ch      (req_bus.ch),
      .last    (req_bus.last),
      .top_name(cell_q[0]),
      .name_buf(name_buf),
      .ctl     (ctl),
      .result  (result)
   );

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [NAME_W-1:0] above;
      logic [NAME_W-1:0] below;
      if (i == 0) begin : g_head
         assign above = name_buf;
      end else begin : g_mid
         assign above = cell_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_tail
         assign below = '0;
      end else begin : g_body
         assign below = cell_q[i+1];
      end
      mtnc_cell #(
         .NAME_W(NAME_W)
      ) u_cell (
         .clock(clock),
         .ctl  (ctl),
         .above(above),
         .below(below),
         .q    (cell_q[i])
      );
   end

   assign push_res = accept && req_bus.last;
   assign pop_res  = out_valid_ff && rsp_bus.ready;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff) begin
         out_valid_in = push_res;
         out_in       = result;
      end else if (pop_res) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = push_res;
            skid_in       = result;
         end else begin
            out_valid_in = push_res;
            out_in       = result;
         end
      end else if (push_res) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.valid_res = out_ff.valid_res;
   assign rsp_bus.fault     = out_ff.fault;

   `MTNC_ASSERT_IMPL(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `MTNC_ASSERT_NEXT(a_last_gives_rsp, clock, reset, push_res, out_valid_ff)
   `MTNC_ASSERT_IMPL(a_no_push_and_pop, clock, reset, ctl.push, !ctl.pop)
   `MTNC_ASSERT_IMPL(a_verdict_flag, clock, reset, out_valid_ff, out_ff.valid_res == (out_ff.fault == mtnc_pkg::F_OK))

endmodule

>>> sim/testbench.sv
// Testbench for the markup tag nesting checker: random markup strings checked against a predictor.
`timescale 1ns / 1ps
package nest_board_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int NAME_CHARS  = 8;

   class verdict_board;
      logic [63:0]          tag_stack [STACK_DEPTH];
      int unsigned          tag_depth;
      logic [63:0]          cur_name;
      int unsigned          cur_len;
      mtnc_pkg::phase_type  phase;
      logic [2:0]           fault_seen;
      mtnc_pkg::result_type verdict_q[$];
      int                   verdicts_noted;
      int                   verdicts_checked;
      int                   errors;

      function new();
         verdicts_noted = 0;
         verdicts_checked = 0;
         errors = 0;
         clear();
      endfunction

      function void clear();
         tag_depth = 0;
         cur_name = '0;
         cur_len = 0;
         phase = mtnc_pkg::PH_OUTSIDE;
         fault_seen = mtnc_pkg::F_OK;
      endfunction

      function int pending();
         return verdict_q.size();
      endfunction

      function void end_tag(bit closing);
         if (!closing) begin
            if (cur_len >= 3 && cur_name[23:0] == mtnc_pkg::NAME_IMG) return;
            if (tag_depth >= STACK_DEPTH) begin
               fault_seen = mtnc_pkg::F_OVERFLOW;
               return;
            end
            tag_stack[tag_depth] = cur_name;
            tag_depth++;
         end else begin
            if (tag_depth == 0) begin
               fault_seen = mtnc_pkg::F_EMPTY;
               return;
            end
            if (tag_stack[tag_depth - 1] != cur_name) begin
               fault_seen = mtnc_pkg::F_MISMATCH;
               return;
            end
            tag_depth--;
         end
      endfunction

      function void take_name_char(logic [7:0] c, bit closing);
         if (c == mtnc_pkg::CH_GT) begin
            end_tag(closing);
            phase = mtnc_pkg::PH_OUTSIDE;
         end else if (c == mtnc_pkg::CH_SPACE || c == mtnc_pkg::CH_SLASH ||
                      c == mtnc_pkg::CH_NUL) begin
            phase = closing ? mtnc_pkg::PH_CLOSE_SKIP : mtnc_pkg::PH_OPEN_SKIP;
         end else if (cur_len >= NAME_CHARS) begin
            fault_seen = mtnc_pkg::F_OVERFLOW;
         end else begin
            cur_name[8 * cur_len +: 8] = c;
            cur_len++;
         end
      endfunction

      function void parse(logic [7:0] c);
         case (phase)
            mtnc_pkg::PH_OUTSIDE: begin
               if (c == mtnc_pkg::CH_LT) begin
                  cur_name = '0;
                  cur_len = 0;
                  phase = mtnc_pkg::PH_AFTER_LT;
               end
            end
            mtnc_pkg::PH_AFTER_LT: begin
               if (c == mtnc_pkg::CH_SLASH) begin
                  phase = mtnc_pkg::PH_CLOSE_NAME;
               end else begin
                  phase = mtnc_pkg::PH_OPEN_NAME;
                  take_name_char(c, 1'b0);
               end
            end
            mtnc_pkg::PH_OPEN_NAME: take_name_char(c, 1'b0);
            mtnc_pkg::PH_CLOSE_NAME: take_name_char(c, 1'b1);
            mtnc_pkg::PH_OPEN_SKIP: begin
               if (c == mtnc_pkg::CH_GT) begin
                  end_tag(1'b0);
                  phase = mtnc_pkg::PH_OUTSIDE;
               end
            end
            mtnc_pkg::PH_CLOSE_SKIP: begin
               if (c == mtnc_pkg::CH_GT) begin
                  end_tag(1'b1);
                  phase = mtnc_pkg::PH_OUTSIDE;
               end
            end
            default: phase = mtnc_pkg::PH_OUTSIDE;
         endcase
      endfunction

      // one accepted character; a verdict is due only on the final one
      function void note_char(logic [7:0] c, logic is_final);
         mtnc_pkg::result_type v;
         if (fault_seen == mtnc_pkg::F_OK) parse(c);
         if (!is_final) return;
         if (fault_seen != mtnc_pkg::F_OK) v.fault = fault_seen;
         else if (phase != mtnc_pkg::PH_OUTSIDE) v.fault = mtnc_pkg::F_UNTERM;
         else if (tag_depth != 0) v.fault = mtnc_pkg::F_UNCLOSED;
         else v.fault = mtnc_pkg::F_OK;
         v.valid_res = (v.fault == mtnc_pkg::F_OK);
         verdict_q.push_back(v);
         verdicts_noted++;
         clear();
      endfunction

      task report(string what, int got, int want);
         $display("verdict %0d: %s got %0d expected %0d", verdicts_checked, what, got, want);
         errors++;
      endtask

      task check_verdict(mtnc_pkg::result_type got);
         mtnc_pkg::result_type want;
         if (verdict_q.size() == 0) begin
            report("unexpected verdict, fault", got.fault, -1);
            return;
         end
         want = verdict_q.pop_front();
         if (got.valid_res !== want.valid_res)
            report("valid_res", got.valid_res, want.valid_res);
         if (got.fault !== want.fault) report("fault", got.fault, want.fault);
         verdicts_checked++;
      endtask
   endclass
endpackage

module testbench;

   localparam int IDLE_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;

   logic clock;
   logic reset;
   mtnc_req_if req_bus();
   mtnc_rsp_if rsp_bus();

   nest_board_pkg::verdict_board sb = new();

   logic [7:0] text_q[$];
   logic [7:0] gname [0:31][0:9];
   int         glen [0:31];
   bit         calm = 1'b0;
   bit         hold_req = 1'b0;
   int         chars_sent = 0;
   int         idle_cycles = 0;

   markup_tag_nesting_checker_core #(
      .STACK_DEPTH(nest_board_pkg::STACK_DEPTH),
      .NAME_CHARS(nest_board_pkg::NAME_CHARS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 9))
         0: return mtnc_pkg::CH_LT;
         1: return mtnc_pkg::CH_GT;
         2: return mtnc_pkg::CH_SLASH;
         3: return ($urandom_range(0, 1) != 0) ? mtnc_pkg::CH_SPACE : mtnc_pkg::CH_NUL;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] name_byte();
      string pool;
      logic [7:0] c;
      pool = "abcdgim";
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return pool[$urandom_range(0, pool.len() - 1)];
         6: return mtnc_pkg::CH_LT;
         7: begin
            do c = 8'($urandom_range(1, 255));
            while (c == mtnc_pkg::CH_SPACE || c == mtnc_pkg::CH_SLASH ||
                   c == mtnc_pkg::CH_GT);
            return c;
         end
         default: return 8'($urandom_range(8'h61, 8'h7A));
      endcase
   endfunction

   function automatic void make_name(int idx, int len_hint);
      int n;
      int r;
      r = $urandom_range(0, 99);
      if (len_hint >= 0) n = len_hint;
      else if (r < 6) n = 0;
      else if (r < 14) n = $urandom_range(7, 9);
      else n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++) gname[idx][k] = name_byte();
      if (n >= 3 && $urandom_range(0, 6) == 0) begin
         gname[idx][0] = "i";
         gname[idx][1] = "m";
         gname[idx][2] = "g";
      end
      glen[idx] = n;
   endfunction

   function automatic bit void_name(int idx);
      return glen[idx] >= 3 && gname[idx][0] == "i" && gname[idx][1] == "m"
         && gname[idx][2] == "g";
   endfunction

   function automatic void emit_tag(int idx, bit closing);
      logic [7:0] c;
      text_q.push_back(mtnc_pkg::CH_LT);
      if (closing) text_q.push_back(mtnc_pkg::CH_SLASH);
      for (int k = 0; k < glen[idx]; k++) text_q.push_back(gname[idx][k]);
      case ($urandom_range(0, 9))
         0, 1: begin
            text_q.push_back(($urandom_range(0, 3) == 0) ?
                             mtnc_pkg::CH_NUL : mtnc_pkg::CH_SPACE);
            repeat ($urandom_range(0, 4)) begin
               do c = noise_byte();
               while (c == mtnc_pkg::CH_GT);
               text_q.push_back(c);
            end
         end
         2: if (!closing) text_q.push_back(mtnc_pkg::CH_SLASH);
         default: ;
      endcase
      text_q.push_back(mtnc_pkg::CH_GT);
   endfunction

   function automatic void emit_text();
      logic [7:0] c;
      repeat ($urandom_range(1, 4)) begin
         do c = 8'($urandom_range(0, 255));
         while (c == mtnc_pkg::CH_LT);
         text_q.push_back(c);
      end
   endfunction

   // mostly nested markup with random names; some noise, deep nesting and damage
   function automatic void build_doc();
      int mode;
      int depth;
      int d;
      int r;
      int flaw;
      int pos;
      mode = $urandom_range(0, 19);
      flaw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : -1;
      depth = 0;
      text_q.delete();
      if (mode == 0) begin
         d = $urandom_range(14, 17);
         for (int i = 0; i < d; i++) begin
            make_name(i, 1);
            emit_tag(i, 1'b0);
         end
         for (int i = d - 1; i >= 0; i--) emit_tag(i, 1'b1);
      end else if (mode < 4) begin
         repeat ($urandom_range(1, 16)) text_q.push_back(noise_byte());
      end else begin
         repeat ($urandom_range(2, 12)) begin
            r = $urandom_range(0, 9);
            if (r < 4 && depth < 20) begin
               make_name(depth, -1);
               emit_tag(depth, 1'b0);
               if (!void_name(depth)) depth++;
            end else if (r < 7 && depth > 0) begin
               depth--;
               emit_tag(depth, 1'b1);
            end else begin
               emit_text();
            end
         end
         if (flaw != 4)
            while (depth > 0) begin
               depth--;
               emit_tag(depth, 1'b1);
            end
      end
      if (text_q.size() > 0) begin
         pos = $urandom_range(0, text_q.size() - 1);
         case (flaw)
            0: text_q.delete(text_q.size() - 1);
            1: text_q.insert(pos, noise_byte());
            2: text_q[pos][$urandom_range(0, 7)] ^= 1'b1;
            3: text_q.delete(pos);
            default: ;
         endcase
      end
      if (text_q.size() == 0) text_q.push_back(noise_byte());
   endfunction

   task automatic send_char(input logic [7:0] c, input logic is_final);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.ch <= c;
      req_bus.last <= is_final;
      do @(posedge clock);
      while (!req_bus.ready);
      chars_sent++;
   endtask

   task automatic send_doc();
      for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // receiver: random stalls, calm stretches, one long hold on request
   initial begin
      int stall;
      int hold;
      stall = 0;
      hold = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            rsp_bus.ready <= (stall == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) sb.note_char(req_bus.ch, req_bus.last);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_verdict('{valid_res: rsp_bus.valid_res, fault: rsp_bus.fault});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[markup_tag_nesting_checker_core] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.ch <= 8'h00;
      req_bus.last <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // clean nesting, close on empty, lone open bracket, unclosed, mismatch
      send_string("<a></a>");
      send_string("</b>");
      send_string("<");
      send_string("<x>");
      send_string("<a></b>");

      // long receiver hold with short strings queued behind it
      calm = 1'b1;
      hold_req = 1'b1;
      repeat (8) begin
         text_q.delete();
         repeat ($urandom_range(1, 3)) text_q.push_back(noise_byte());
         send_doc();
      end

      // sender idles until every verdict is back
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);

      while (chars_sent < 500) begin
         calm = ($urandom_range(0, 4) == 0);
         build_doc();
         send_doc();
      end
      req_bus.valid <= 1'b0;
      @(posedge clock);

      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("[markup_tag_nesting_checker_core] OK");
      else
         $display("[markup_tag_nesting_checker_core] ERROR");
      $finish;
   end
endmodule
